// File: design/sis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sis_pkg
// shared types and constants of the sorted id set engine
// ----------------------------------------------------------------------------
package sis_pkg;

  localparam int DEF_ID_CAPACITY = 256;
  localparam int DEF_ID_WIDTH    = 32;
  localparam int BODY_ID_W       = 32;
  localparam int COUNT_W         = 9;

  typedef enum logic [1:0] {
    REQ_QUERY  = 2'd0,
    REQ_ADD    = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  // table read address source
  typedef enum logic [1:0] {
    RD_MID,
    RD_POS,
    RD_IDX_M1,
    RD_IDX_P1
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    step;
    logic    hit_cap;
    logic    dropped_set;
    logic    idx_up_init;
    logic    idx_dn_init;
    logic    idx_dec;
    logic    idx_inc;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    wr_shift;
    logic    wr_key;
    logic    cnt_inc;
    logic    cnt_dec;
    logic    cnt_clr;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic lo_lt_hi;
    logic pos_lt_cnt;
    logic hit;
    logic full;
    logic up_more;
    logic dn_more;
    logic out_free;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: design/sis_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sis_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module sis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: design/sis_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sis_datapath
// search bounds, shift index, held count, id table and result register
// ----------------------------------------------------------------------------
module sis_datapath #(
  parameter int ID_CAPACITY = sis_pkg::DEF_ID_CAPACITY,
  parameter int ID_WIDTH    = sis_pkg::DEF_ID_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire sis_pkg::dp_cmd_t              cmd,
  output sis_pkg::dp_sts_t                   sts,
  input  wire logic [1:0]                    req_type,
  input  wire logic [sis_pkg::BODY_ID_W-1:0] body_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               was_member,
  output logic                               dropped_full,
  output logic [sis_pkg::COUNT_W-1:0]        entry_count
);
  import sis_pkg::*;

  localparam int CNT_W  = $clog2(ID_CAPACITY + 1);
  localparam int ADDR_W = $clog2(ID_CAPACITY);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(ID_CAPACITY);

  req_t              req;
  logic [ID_WIDTH-1:0] key;
  logic [CNT_W-1:0]  lo;
  logic [CNT_W-1:0]  hi;
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  cnt;
  logic              hit;
  logic              dropped;

  logic [63:0]         body_ext;
  logic [ID_WIDTH-1:0] key_in;
  logic [CNT_W-1:0]    span;
  logic [CNT_W-1:0]    mid;
  logic [CNT_W-1:0]    idx_m1;
  logic [CNT_W-1:0]    idx_p1;
  logic [CNT_W-1:0]    raddr_full;
  logic [CNT_W-1:0]    waddr_full;
  logic [ID_WIDTH-1:0] wdata;
  logic [ID_WIDTH-1:0] rdata;
  logic [CNT_W+COUNT_W-1:0] cnt_ext;

  assign body_ext = {{(64 - BODY_ID_W){1'b0}}, body_id};
  assign key_in   = body_ext[ID_WIDTH-1:0];
  assign span     = hi - lo;
  assign mid      = lo + (span >> 1);
  assign idx_m1   = idx - CNT_W'(1);
  assign idx_p1   = idx + CNT_W'(1);

  always_comb begin
    case (cmd.rd_sel)
      RD_MID:    raddr_full = mid;
      RD_POS:    raddr_full = lo;
      RD_IDX_M1: raddr_full = idx_m1;
      RD_IDX_P1: raddr_full = idx_p1;
      default:   raddr_full = lo;
    endcase
  end

  assign waddr_full = cmd.wr_key ? lo : idx;
  assign wdata      = cmd.wr_key ? key : rdata;

  sis_ram #(
    .WIDTH (ID_WIDTH),
    .DEPTH (ID_CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_shift | cmd.wr_key),
    .waddr (waddr_full[ADDR_W-1:0]),
    .wdata (wdata),
    .re    (cmd.rd_en),
    .raddr (raddr_full[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // payload and search state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req     <= req_t'(req_type);
      key     <= key_in;
      lo      <= '0;
      hi      <= cnt;
      hit     <= 1'b0;
      dropped <= 1'b0;
    end else begin
      if (cmd.step) begin
        if (rdata < key) begin
          lo <= mid + CNT_W'(1);
        end else begin
          hi <= mid;
        end
      end
      if (cmd.hit_cap) begin
        hit <= (rdata == key);
      end
      if (cmd.dropped_set) begin
        dropped <= 1'b1;
      end
    end
    if (cmd.idx_up_init) begin
      idx <= cnt;
    end else if (cmd.idx_dn_init) begin
      idx <= lo;
    end else if (cmd.idx_dec) begin
      idx <= idx_m1;
    end else if (cmd.idx_inc) begin
      idx <= idx_p1;
    end
  end

  // held count
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.cnt_clr) begin
      cnt <= '0;
    end else if (cmd.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign cnt_ext = {{COUNT_W{1'b0}}, cnt};

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      was_member   <= hit;
      dropped_full <= dropped;
      entry_count  <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign sts.req        = req;
  assign sts.lo_lt_hi   = (lo < hi);
  assign sts.pos_lt_cnt = (lo < cnt);
  assign sts.hit        = hit;
  assign sts.full       = (cnt >= CAP);
  assign sts.up_more    = (idx > lo);
  assign sts.dn_more    = (idx_p1 < cnt);
  assign sts.out_free   = !out_valid || out_ready;

endmodule
`default_nettype wire

// File: design/sis_controller.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sis_controller
// request sequencer: search, membership check, shift loops, result hand-off
// ----------------------------------------------------------------------------
module sis_controller (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire sis_pkg::dp_sts_t sts,
  output sis_pkg::dp_cmd_t      cmd
);
  import sis_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_SCMP,
    ST_CHK,
    ST_CCMP,
    ST_DEC,
    ST_UPRD,
    ST_UPWR,
    ST_KEYWR,
    ST_DNRD,
    ST_DNWR,
    ST_FIN
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_MID;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SRCH;
        end
      end
      ST_SRCH: begin
        if (sts.req == REQ_CLEAR) begin
          cmd.cnt_clr = 1'b1;
          state_next  = ST_FIN;
        end else if (sts.lo_lt_hi) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_MID;
          state_next = ST_SCMP;
        end else begin
          state_next = ST_CHK;
        end
      end
      ST_SCMP: begin
        cmd.step   = 1'b1;
        state_next = ST_SRCH;
      end
      ST_CHK: begin
        if (sts.pos_lt_cnt) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_POS;
          state_next = ST_CCMP;
        end else begin
          state_next = ST_DEC;
        end
      end
      ST_CCMP: begin
        cmd.hit_cap = 1'b1;
        state_next  = ST_DEC;
      end
      ST_DEC: begin
        case (sts.req)
          REQ_ADD: begin
            if (sts.hit) begin
              state_next = ST_FIN;
            end else if (sts.full) begin
              cmd.dropped_set = 1'b1;
              state_next      = ST_FIN;
            end else begin
              cmd.idx_up_init = 1'b1;
              state_next      = ST_UPRD;
            end
          end
          REQ_REMOVE: begin
            if (sts.hit) begin
              cmd.idx_dn_init = 1'b1;
              state_next      = ST_DNRD;
            end else begin
              state_next = ST_FIN;
            end
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_UPRD: begin
        if (sts.up_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_M1;
          state_next = ST_UPWR;
        end else begin
          state_next = ST_KEYWR;
        end
      end
      ST_UPWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_dec  = 1'b1;
        state_next   = ST_UPRD;
      end
      ST_KEYWR: begin
        cmd.wr_key  = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_next  = ST_FIN;
      end
      ST_DNRD: begin
        if (sts.dn_more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_IDX_P1;
          state_next = ST_DNWR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_next  = ST_FIN;
        end
      end
      ST_DNWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = ST_DNRD;
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/sorted_id_set_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_set_engine
// sorted set of unique ids with query, add, remove and clear requests
// ----------------------------------------------------------------------------
// Requests are handled one at a time; every request yields one result. The ids
// sit in ascending order in a single ram (one read and one write a cycle), so
// the cost is set by that port: a binary search reads and compares once per
// halving step, the membership check reads the found position once more if it
// lies below the count, an add of a new id shifts the tail up one place, and a
// remove hit shifts it down. A clear only empties the count. The hand-off waits
// as long as the result register stays blocked. The table needs no clearing
// pass after reset: only entries below the count are ever read. A new request
// is taken while the previous result still waits in the output register.
// ----------------------------------------------------------------------------
module sorted_id_set_engine #(
  parameter int ID_CAPACITY = sis_pkg::DEF_ID_CAPACITY,
  parameter int ID_WIDTH    = sis_pkg::DEF_ID_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // request channel
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [sis_pkg::BODY_ID_W-1:0] body_id,
  // result channel
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               was_member,
  output logic                               dropped_full,
  output logic [sis_pkg::COUNT_W-1:0]        entry_count
);
  import sis_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: one request transfer at a time, steps the datapath
  sis_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // search bounds, shift index, id table, held count and result register
  sis_datapath #(
    .ID_CAPACITY (ID_CAPACITY),
    .ID_WIDTH    (ID_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .body_id      (body_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .was_member   (was_member),
    .dropped_full (dropped_full),
    .entry_count  (entry_count)
  );

endmodule
`default_nettype wire

// File: design/sis_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sis_checker
// port-level checks of the sorted id set engine
// ----------------------------------------------------------------------------
module sis_checker #(
  parameter int ID_CAPACITY = sis_pkg::DEF_ID_CAPACITY
) (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic                        was_member,
  input wire logic                        dropped_full,
  input wire logic [sis_pkg::COUNT_W-1:0] entry_count
);
  import sis_pkg::*;

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(ID_CAPACITY % (1 << COUNT_W));

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(entry_count)
      && $stable(was_member) && $stable(dropped_full))
    else $error("result changed while stalled");

  // a refused add cannot also report a member
  a_drop_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(was_member && dropped_full))
    else $error("dropped and member both set");

  // a refused add only happens at full count
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_full |-> entry_count == FULL_COUNT)
    else $error("dropped below capacity");

  // requests are served one at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

endmodule

bind sorted_id_set_engine sis_checker #(
  .ID_CAPACITY (ID_CAPACITY)
) u_sis_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .was_member   (was_member),
  .dropped_full (dropped_full),
  .entry_count  (entry_count)
);
`default_nettype wire

// File: tb/sorted_id_set_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_set_checker
// watches both channels of the sorted id set engine and scores its results
// ----------------------------------------------------------------------------
// Keeps its own ascending copy of the id set. Every request transfer is
// applied to that copy, and the result it gives is queued. Every result
// transfer is checked field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module sorted_id_set_checker #(
  parameter int ID_CAPACITY = sis_pkg::DEF_ID_CAPACITY
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [1:0]                    req_type,
  input  wire logic [sis_pkg::BODY_ID_W-1:0] body_id,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic                          was_member,
  input  wire logic                          dropped_full,
  input  wire logic [sis_pkg::COUNT_W-1:0]   entry_count,
  output int                                 error_count,
  output int                                 pending,
  output int                                 result_count,
  output int                                 hit_count,
  output int                                 refused_count,
  output int                                 peak_fill
);
  import sis_pkg::*;

  typedef struct {
    logic               member;
    logic               dropped;
    logic [COUNT_W-1:0] count;
  } set_result_t;

  logic [BODY_ID_W-1:0] held_ids[$];
  set_result_t          expected_results[$];

  initial begin
    error_count   = 0;
    pending       = 0;
    result_count  = 0;
    hit_count     = 0;
    refused_count = 0;
    peak_fill     = 0;
  end

  task automatic report_error(string msg);
    error_count++;
    $display("[%0t] result mismatch: %s", $realtime, msg);
  endtask

  // lower-bound search, then insert, delete or empty the held ids
  function automatic set_result_t apply_request(req_t kind, logic [BODY_ID_W-1:0] id);
    set_result_t res;
    int          slot;
    bit          found;
    res.member  = 1'b0;
    res.dropped = 1'b0;
    if (kind == REQ_CLEAR) begin
      held_ids.delete();
    end else begin
      slot = 0;
      while (slot < held_ids.size() && held_ids[slot] < id) slot++;
      found = (slot < held_ids.size()) && (held_ids[slot] == id);
      res.member = found;
      if (kind == REQ_ADD && !found) begin
        if (held_ids.size() >= ID_CAPACITY) begin
          res.dropped = 1'b1;
        end else begin
          held_ids.insert(slot, id);
        end
      end else if (kind == REQ_REMOVE && found) begin
        held_ids.delete(slot);
      end
    end
    res.count = COUNT_W'(held_ids.size());
    return res;
  endfunction

  always @(posedge clk) begin
    set_result_t want;
    if (rst) begin
      held_ids.delete();
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_error($sformatf("result with no request outstanding (count %0d)",
                                 entry_count));
        end else begin
          want = expected_results.pop_front();
          result_count++;
          if (was_member !== want.member) begin
            report_error($sformatf("result %0d was_member %b, want %b",
                                   result_count, was_member, want.member));
          end
          if (dropped_full !== want.dropped) begin
            report_error($sformatf("result %0d dropped_full %b, want %b",
                                   result_count, dropped_full, want.dropped));
          end
          if (entry_count !== want.count) begin
            report_error($sformatf("result %0d entry_count %0d, want %0d",
                                   result_count, entry_count, want.count));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = apply_request(req_t'(req_type), body_id);
        expected_results.insert(expected_results.size(), want);
        if (want.member) hit_count++;
        if (want.dropped) refused_count++;
        if (int'(want.count) > peak_fill) peak_fill = int'(want.count);
      end
    end
    pending = expected_results.size();
  end

endmodule
`default_nettype wire

// File: tb/sorted_id_set_engine_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_id_set_engine_test
// stimulus and verdict for the sorted id set engine
// ----------------------------------------------------------------------------
// A short directed run over empty-set, edge-of-range and duplicate cases, two
// runs that fill the table to capacity and push past it, and random request
// sequences over small id pools so that hits, misses, inserts and deletes all
// happen often. Both channels idle at random; in two runs the result side holds off
// long enough to back the engine up into its request port.
// ----------------------------------------------------------------------------
module sorted_id_set_engine_test;
  import sis_pkg::*;

  localparam int     ID_CAP       = DEF_ID_CAPACITY;
  localparam int     ITEM_TARGET  = 1900;
  localparam int     HOLD_CYCLES  = 400;
  // worst single request: search plus a full tail shift
  localparam int     DRAIN_CYCLES = 700;
  localparam longint LIMIT_TIME   = 64'd12 * 64'd5_000_000;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           req_type;
  logic [BODY_ID_W-1:0] body_id;
  logic                 out_valid;
  logic                 out_ready;
  logic                 was_member;
  logic                 dropped_full;
  logic [COUNT_W-1:0]   entry_count;

  int error_count;
  int pending;
  int result_count;
  int hit_count;
  int refused_count;
  int peak_fill;

  int sent_count    = 0;
  bit burst         = 1'b0;  // sender offers back to back when set
  bit hold_results  = 1'b0;  // asks the result side for one long hold-off

  always #6 clk = ~clk;

  sorted_id_set_engine i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .req_type     (req_type),
    .body_id      (body_id),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .was_member   (was_member),
    .dropped_full (dropped_full),
    .entry_count  (entry_count)
  );

  sorted_id_set_checker #(.ID_CAPACITY(ID_CAP)) i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .body_id       (body_id),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .was_member    (was_member),
    .dropped_full  (dropped_full),
    .entry_count   (entry_count),
    .error_count   (error_count),
    .pending       (pending),
    .result_count  (result_count),
    .hit_count     (hit_count),
    .refused_count (refused_count),
    .peak_fill     (peak_fill)
  );

  // hard stop in case the engine hangs or a result never shows up
  initial begin
    #(LIMIT_TIME);
    $display("timeout with %0d results outstanding", pending);
    $display("DONE: errors detected");
    $finish;
  end

  // ------------------------------------------------------------------------
  // request side
  // ------------------------------------------------------------------------

  // one request transfer; called at a falling edge, returns at a falling edge
  // valid is only lowered when a gap is drawn, so back to back stays high
  task automatic send_request(req_t kind, logic [BODY_ID_W-1:0] id);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    body_id  <= id;
    do @(posedge clk); while (!in_ready);
    sent_count++;
    @(negedge clk);
  endtask

  // sender goes quiet until every result is back
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // edges of the id range, duplicates, misses and clears on a tiny set
  task automatic run_directed();
    send_request(REQ_QUERY,  32'h0000_0000);  // query on empty set
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);  // remove on empty set
    send_request(REQ_CLEAR,  32'h1234_5678);  // clear on empty set
    send_request(REQ_ADD,    32'h8000_0000);
    send_request(REQ_ADD,    32'h0000_0000);  // new head
    send_request(REQ_ADD,    32'hFFFF_FFFF);  // new tail
    send_request(REQ_ADD,    32'h8000_0000);  // duplicate add
    send_request(REQ_QUERY,  32'h0000_0000);
    send_request(REQ_QUERY,  32'hFFFF_FFFF);
    send_request(REQ_QUERY,  32'h7FFF_FFFF);  // miss between members
    send_request(REQ_ADD,    32'h5555_5555);
    send_request(REQ_ADD,    32'hAAAA_AAAA);
    send_request(REQ_REMOVE, 32'h8000_0000);  // remove from the middle
    send_request(REQ_REMOVE, 32'h8000_0000);  // now absent
    send_request(REQ_REMOVE, 32'h0000_0000);  // remove the head
    send_request(REQ_REMOVE, 32'hFFFF_FFFF);  // remove the tail
    send_request(REQ_QUERY,  32'h5555_5555);
    send_request(REQ_CLEAR,  32'hFFFF_FFFF);  // id ignored on clear
    send_request(REQ_QUERY,  32'h5555_5555);
    send_request(REQ_ADD,    32'h0000_0001);
    send_request(REQ_ADD,    32'hFFFF_FFFE);
    send_request(REQ_REMOVE, 32'h0000_0001);
    send_request(REQ_REMOVE, 32'hFFFF_FFFE);  // back to empty
    drain_results();
  endtask

  // fill the table in shuffled order, then push past capacity
  task automatic fill_to_capacity(bit squeeze);
    logic [BODY_ID_W-1:0] fill_ids[ID_CAP];
    logic [BODY_ID_W-1:0] swap_id;
    int                   j;
    // distinct top bytes keep the ids unique
    for (int k = 0; k < ID_CAP; k++) begin
      fill_ids[k] = (BODY_ID_W'(k) << 24) | BODY_ID_W'($urandom_range(0, 32'h00FF_FFFF));
    end
    for (int k = ID_CAP - 1; k > 0; k--) begin
      j           = $urandom_range(0, k);
      swap_id     = fill_ids[k];
      fill_ids[k] = fill_ids[j];
      fill_ids[j] = swap_id;
    end
    burst = ($urandom_range(0, 1) == 0);
    send_request(REQ_CLEAR, $urandom);
    for (int k = 0; k < ID_CAP; k++) begin
      // long result hold-off while requests keep coming
      if (squeeze && k == 20) hold_results = 1'b1;
      send_request(REQ_ADD, fill_ids[k]);
    end
    // table full: new ids are refused, held ids still report membership
    repeat (6) send_request(REQ_ADD, $urandom);
    send_request(REQ_ADD, 32'hFFFF_FFFF);
    send_request(REQ_ADD, 32'h0000_0000);
    repeat (4) send_request(REQ_ADD, fill_ids[$urandom_range(0, ID_CAP - 1)]);
    repeat (4) send_request(REQ_QUERY, fill_ids[$urandom_range(0, ID_CAP - 1)]);
    repeat (3) send_request(REQ_QUERY, $urandom);
    // make room, then fill it again and overflow once more
    for (int k = 0; k < 3; k++) send_request(REQ_REMOVE, fill_ids[k]);
    send_request(REQ_REMOVE, fill_ids[0]);
    for (int k = 0; k < 3; k++) send_request(REQ_ADD, fill_ids[k]);
    send_request(REQ_ADD, $urandom);
    drain_results();
  endtask

  // random id from a pool, sometimes a full-range stray
  function automatic logic [BODY_ID_W-1:0] pick_id(ref logic [BODY_ID_W-1:0] pool[$]);
    if ($urandom_range(0, 99) < 4) return $urandom;
    return pool[$urandom_range(0, pool.size() - 1)];
  endfunction

  // mixed requests over a small pool so that hits and misses both happen
  task automatic run_mixed_sequence(bit squeeze);
    logic [BODY_ID_W-1:0] pool[$];
    logic [BODY_ID_W-1:0] base;
    int                   pool_size;
    int                   style;
    int                   len;
    int                   roll;
    pool_size = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(4, 40);
    style     = $urandom_range(0, 2);
    base      = $urandom;
    for (int k = 0; k < pool_size; k++) begin
      case (style)
        0: begin
          pool.insert(pool.size(), $urandom);
        end
        1: begin
          // clustered ids, each a common base plus 0 to 63
          pool.insert(pool.size(), base + BODY_ID_W'($urandom_range(0, 63)));
        end
        default: begin
          // range edges, single-bit ids and their inverses
          case ($urandom_range(0, 5))
            0: pool.insert(pool.size(), 32'h0000_0000);
            1: pool.insert(pool.size(), 32'hFFFF_FFFF);
            2: pool.insert(pool.size(), 32'h8000_0000);
            3: pool.insert(pool.size(), 32'h7FFF_FFFF);
            4: pool.insert(pool.size(), 32'h1 << $urandom_range(0, 31));
            default: pool.insert(pool.size(), ~(32'h1 << $urandom_range(0, 31)));
          endcase
        end
      endcase
    end
    burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) send_request(REQ_CLEAR, $urandom);
    len = $urandom_range(20, 60);
    for (int k = 0; k < len; k++) begin
      if (squeeze && k == 2) hold_results = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        send_request(REQ_QUERY, pick_id(pool));
      end else if (roll < 70) begin
        send_request(REQ_ADD, pick_id(pool));
      end else if (roll < 98) begin
        send_request(REQ_REMOVE, pick_id(pool));
      end else begin
        send_request(REQ_CLEAR, $urandom);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // result side: random stall per result, steady stretches, two runs with a long hold
  // ------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    int served;
    bit steady;
    out_ready = 1'b0;
    served    = 0;
    steady    = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (served % 50 == 0) steady = ($urandom_range(0, 2) == 0);
      stall = steady ? 0 : $urandom_range(0, 14);
      if (hold_results) begin
        stall        = stall + HOLD_CYCLES;
        hold_results = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      served++;
      @(negedge clk);
    end
  end

  // ------------------------------------------------------------------------
  // main sequence
  // ------------------------------------------------------------------------
  initial begin
    int seq_index;
    rst      = 1'b1;
    in_valid = 1'b0;
    req_type = REQ_QUERY;
    body_id  = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    fill_to_capacity(1'b1);

    seq_index = 0;
    while (sent_count < 1100) begin
      run_mixed_sequence(seq_index == 5);
      // sometimes let everything come back before going on
      if ($urandom_range(0, 3) == 0) drain_results();
      seq_index++;
    end

    drain_results();
    fill_to_capacity(1'b0);

    while (sent_count < ITEM_TARGET) begin
      run_mixed_sequence(1'b0);
      if ($urandom_range(0, 3) == 0) drain_results();
    end

    // all requests in, wait out the results and any stray output
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d requests and %0d checked results: %0d member hits,",
             sent_count, result_count, hit_count);
    $display("%0d adds refused on a full table, peak fill %0d of %0d ids",
             refused_count, peak_fill, ID_CAP);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire
